// File: sv/cce_pkg.sv
`default_nettype none

package cce_pkg;

  localparam int unsigned PixW    = 4;
  localparam int unsigned NumPix  = 8;
  localparam int unsigned NumRows = 8;
  localparam int unsigned RowW    = $clog2(NumRows);
  localparam int unsigned ColW    = 4;
  localparam int unsigned McW     = 5;
  localparam int unsigned CfgDataW = 5;

  localparam logic [PixW-1:0] BgReset  = 4'd0;
  localparam logic [McW-1:0]  Mc1Reset = 5'd12;
  localparam logic [McW-1:0]  Mc2Reset = 5'd13;
  localparam logic [7:0]      ByteFull = 8'hff;
  localparam logic [ColW-1:0] MultiFlag = 4'd8;

  // mode_force bits
  localparam int unsigned ForceHiresBit = 0;
  localparam int unsigned ForceMultiBit = 1;

  typedef enum logic [1:0] {
    CfgBackground = 2'd0,
    CfgMulticolOne = 2'd1,
    CfgMulticolTwo = 2'd2,
    CfgModeForce   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PixW-1:0] pixel_0;
    logic [PixW-1:0] pixel_1;
    logic [PixW-1:0] pixel_2;
    logic [PixW-1:0] pixel_3;
    logic [PixW-1:0] pixel_4;
    logic [PixW-1:0] pixel_5;
    logic [PixW-1:0] pixel_6;
    logic [PixW-1:0] pixel_7;
  } pix_row_t;

  typedef struct packed {
    logic [7:0]      byte_0;
    logic [7:0]      byte_1;
    logic [7:0]      byte_2;
    logic [7:0]      byte_3;
    logic [7:0]      byte_4;
    logic [7:0]      byte_5;
    logic [7:0]      byte_6;
    logic [7:0]      byte_7;
    logic [ColW-1:0] cell_colour;
    logic            coalesce_ok;
  } cell_res_t;

endpackage

`default_nettype wire

// File: sv/char_cell_mode_encoder.sv
`default_nettype none

// Character cell mode encoder. Takes one row of eight 4-bit palette indices
// per transfer, top row first, and after every eighth row delivers one result:
// eight pattern bytes, a colour nibble and a coalesce flag. One row is taken
// per cycle, except while a stalled eighth row waits; a row passes an input
// register, the per-row packing and the cell classification, and the cell
// result lands in the output register, from which it is offered, once the
// eighth row advances out of the input register. The input side keeps moving
// while a result waits, until the eighth row of the next cell needs the output
// register. Configuration writes take effect on the next cycle; pattern bits
// use the settings current at each row, classification those current at the eighth row.
module char_cell_mode_encoder (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire cce_pkg::cfg_idx_e  cfg_idx_i,
  input  wire [cce_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire cce_pkg::pix_row_t  in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output cce_pkg::cell_res_t      out_data_o
);
  import cce_pkg::*;

  // configuration
  logic [PixW-1:0] bg_q;
  logic [McW-1:0]  mc1_q, mc2_q;
  logic [1:0]      force_q;

  // input register
  logic     s1_valid_q;
  pix_row_t s1_row_q;
  logic     s1_adv;

  // cell accumulators
  logic [RowW-1:0] row_q;
  logic [15:0]     mask_q;
  logic [ColW-1:0] hires_last_q;
  logic [ColW-1:0] multi_col_q;
  logic            multi_plain_q;
  logic [7:0]      hires_rows_q [NumRows];
  logic [7:0]      multi_rows_q [NumRows];

  // output register
  logic      out_valid_q;
  cell_res_t out_data_q;

  // row logic
  logic [PixW-1:0] pix [NumPix];
  logic [7:0]      hbits, mbits;
  logic [15:0]     mask_d;
  logic [ColW-1:0] hires_last_d, multi_col_d;
  logic            multi_plain_d;
  logic            last_row;
  cell_res_t       res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q    <= BgReset;
      mc1_q   <= Mc1Reset;
      mc2_q   <= Mc2Reset;
      force_q <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBackground:  bg_q    <= cfg_wdata_i[PixW-1:0];
        CfgMulticolOne: mc1_q   <= cfg_wdata_i[McW-1:0];
        CfgMulticolTwo: mc2_q   <= cfg_wdata_i[McW-1:0];
        CfgModeForce:   force_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign last_row   = (row_q == RowW'(NumRows - 1));
  assign s1_adv     = s1_valid_q && (!last_row || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_row_q <= in_data_i;
    end
  end

  assign pix[0] = s1_row_q.pixel_0;
  assign pix[1] = s1_row_q.pixel_1;
  assign pix[2] = s1_row_q.pixel_2;
  assign pix[3] = s1_row_q.pixel_3;
  assign pix[4] = s1_row_q.pixel_4;
  assign pix[5] = s1_row_q.pixel_5;
  assign pix[6] = s1_row_q.pixel_6;
  assign pix[7] = s1_row_q.pixel_7;

  // per-row packing; later pixels override the running colours
  always_comb begin
    logic [15:0] row_mask;
    hbits         = 8'd0;
    mbits         = 8'd0;
    row_mask      = 16'd0;
    hires_last_d  = hires_last_q;
    multi_col_d   = multi_col_q;
    multi_plain_d = multi_plain_q;
    for (int x = 0; x < NumPix; x++) begin
      row_mask[pix[x]] = 1'b1;
      if (pix[x] != bg_q) begin
        hbits[7-x]   = 1'b1;
        hires_last_d = pix[x];
      end
      if ((x % 2) == 0) begin
        if ({1'b0, pix[x]} == mc1_q) begin
          mbits[7-x -: 2] = 2'b01;
        end else if ({1'b0, pix[x]} == mc2_q) begin
          mbits[7-x -: 2] = 2'b10;
        end else if (pix[x] != bg_q) begin
          mbits[7-x -: 2] = 2'b11;
          multi_plain_d   = 1'b0;
          multi_col_d     = pix[x] | MultiFlag;
        end
      end
    end
    mask_d = mask_q | row_mask;
  end

  // cell classification on the eighth row
  always_comb begin
    logic [15:0]     bg_bit, other;
    logic            single, single_low, bg_only, hires;
    logic [ColW-1:0] single_col;
    logic [7:0]      bytes [NumRows];
    bg_bit     = 16'd1 << bg_q;
    other      = mask_d & ~bg_bit;
    single     = $onehot(mask_d);
    bg_only    = (mask_d == bg_bit);
    single_low = single && (mask_d[15:8] == 8'd0);
    single_col = '0;
    for (int c = 0; c < 8; c++) begin
      if (mask_d[c]) begin
        single_col = ColW'(c);
      end
    end
    hires = (|(mask_d & bg_bit)) && $onehot(other) && (other[15:8] == 8'd0);
    if (force_q[ForceHiresBit]) begin
      hires = 1'b1;
    end
    if (force_q[ForceMultiBit]) begin
      hires = 1'b0;
    end
    for (int k = 0; k < NumRows; k++) begin
      bytes[k] = 8'd0;
    end
    res_d = '0;
    priority if (bg_only) begin
      res_d.cell_colour = '0;
      res_d.coalesce_ok = 1'b1;
    end else if (single_low) begin
      for (int k = 0; k < NumRows; k++) begin
        bytes[k] = ByteFull;
      end
      res_d.cell_colour = single_col;
      res_d.coalesce_ok = 1'b0;
    end else if (hires) begin
      for (int k = 0; k < NumRows - 1; k++) begin
        bytes[k] = hires_rows_q[k];
      end
      bytes[NumRows-1]  = hbits;
      res_d.cell_colour = hires_last_d;
      res_d.coalesce_ok = 1'b0;
    end else begin
      for (int k = 0; k < NumRows - 1; k++) begin
        bytes[k] = multi_rows_q[k];
      end
      bytes[NumRows-1]  = mbits;
      res_d.cell_colour = multi_col_d;
      res_d.coalesce_ok = multi_plain_d;
    end
    res_d.byte_0 = bytes[0];
    res_d.byte_1 = bytes[1];
    res_d.byte_2 = bytes[2];
    res_d.byte_3 = bytes[3];
    res_d.byte_4 = bytes[4];
    res_d.byte_5 = bytes[5];
    res_d.byte_6 = bytes[6];
    res_d.byte_7 = bytes[7];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q         <= '0;
      mask_q        <= '0;
      hires_last_q  <= '0;
      multi_col_q   <= MultiFlag;
      multi_plain_q <= 1'b1;
    end else if (s1_adv) begin
      if (last_row) begin
        row_q         <= '0;
        mask_q        <= '0;
        hires_last_q  <= '0;
        multi_col_q   <= MultiFlag;
        multi_plain_q <= 1'b1;
      end else begin
        row_q         <= row_q + RowW'(1);
        mask_q        <= mask_d;
        hires_last_q  <= hires_last_d;
        multi_col_q   <= multi_col_d;
        multi_plain_q <= multi_plain_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      hires_rows_q[row_q] <= hbits;
      multi_rows_q[row_q] <= mbits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && last_row) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && last_row) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: sv/cce_checker.sv
`default_nettype none

module cce_checker (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     in_valid_i,
  input wire                     in_ready_o,
  input wire                     out_valid_o,
  input wire                     out_ready_i,
  input wire cce_pkg::cell_res_t out_data_o
);
  import cce_pkg::*;

  logic [RowW-1:0] rows_q;
  logic [1:0]      pending_q;
  logic            in_xfer, out_xfer, cell_done;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign out_xfer  = out_valid_o && out_ready_i;
  assign cell_done = in_xfer && (rows_q == RowW'(NumRows - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q    <= '0;
      pending_q <= '0;
    end else begin
      if (in_xfer) begin
        rows_q <= rows_q + RowW'(1);
      end
      pending_q <= pending_q + {1'b0, cell_done} - {1'b0, out_xfer};
    end
  end

  // a result only shows for a cell whose eighth row has been taken
  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result offered without a completed cell");

  // at most the input register and the output register hold whole cells
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many cells in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // coalescable cells are background-only (colour 0, blank) or plain multicolour
  a_coalesce_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.coalesce_ok |->
      out_data_o.cell_colour == '0 || out_data_o.cell_colour == MultiFlag)
    else $error("coalesce flag with odd colour");

  a_blank_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.coalesce_ok && out_data_o.cell_colour == '0 |->
      out_data_o[$bits(cell_res_t)-1 -: 64] == 64'd0)
    else $error("background cell with pattern bits");

endmodule

bind char_cell_mode_encoder cce_checker u_cce_checker (.*);

`default_nettype wire

// File: sim/char_cell_mode_encoder_test.sv
`timescale 1ns / 1ps

module char_cell_mode_encoder_test;
  import cce_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx_i = CfgBackground;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pix_row_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  cell_res_t out_data_o;

  char_cell_mode_encoder uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // register copies as the encoder should hold them
  logic [PixW-1:0] bg_reg = BgReset;
  logic [McW-1:0] mc_one_reg = Mc1Reset;
  logic [McW-1:0] mc_two_reg = Mc2Reset;
  logic [1:0] force_reg = 2'd0;

  // cell accumulation state
  logic [RowW-1:0] row_idx = '0;
  logic [15:0] colour_mask = '0;
  logic [7:0] hires_pat [NumRows];
  logic [7:0] multi_pat [NumRows];
  logic [ColW-1:0] hires_colour = '0;
  logic [ColW-1:0] multi_col = MultiFlag;
  logic multi_clean = 1'b1;

  pix_row_t row_q[$];
  cell_res_t cell_q[$];
  int mismatches = 0;
  bit row_taken = 1'b0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  task automatic flag(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  task automatic encode_row(input pix_row_t r);
    logic [31:0] flat;
    logic [3:0] p;
    logic [7:0] hb, mb;
    logic [7:0] pat [NumRows];
    logic [ColW-1:0] col;
    logic co;
    int n, c1, c2;
    bit hires;
    cell_res_t res;
    flat = r;
    hb = '0;
    mb = '0;
    for (int x = 0; x < NumPix; x++) begin
      p = flat[31-4*x -: 4];
      colour_mask[p] = 1'b1;
      if (p != bg_reg) begin
        hb[7-x] = 1'b1;
        hires_colour = p;
      end
      if (x % 2 == 0) begin
        if ({1'b0, p} == mc_one_reg) begin
          mb[7-x -: 2] = 2'b01;
        end else if ({1'b0, p} == mc_two_reg) begin
          mb[7-x -: 2] = 2'b10;
        end else if (p != bg_reg) begin
          mb[7-x -: 2] = 2'b11;
          multi_clean = 1'b0;
          multi_col = p | MultiFlag;
        end
      end
    end
    hires_pat[row_idx] = hb;
    multi_pat[row_idx] = mb;
    if (row_idx != RowW'(NumRows - 1)) begin
      row_idx++;
      return;
    end

    n = 0;
    c1 = 0;
    c2 = 0;
    for (int c = 0; c < 16; c++) begin
      if (colour_mask[c]) begin
        if (n == 0) c1 = c;
        else if (n == 1) c2 = c;
        n++;
      end
    end
    if (n == 1 && c1 == bg_reg) begin
      for (int k = 0; k < NumRows; k++) pat[k] = 8'h00;
      col = '0;
      co = 1'b1;
    end else if (n == 1 && c1 < 8) begin
      for (int k = 0; k < NumRows; k++) pat[k] = ByteFull;
      col = c1[ColW-1:0];
      co = 1'b0;
    end else begin
      hires = (n == 2) && ((c1 == bg_reg && c2 < 8) || (c1 < 8 && c2 == bg_reg));
      if (force_reg[ForceHiresBit]) hires = 1'b1;
      if (force_reg[ForceMultiBit]) hires = 1'b0;
      for (int k = 0; k < NumRows; k++) pat[k] = hires ? hires_pat[k] : multi_pat[k];
      col = hires ? hires_colour : multi_col;
      co = hires ? 1'b0 : multi_clean;
    end
    res = {pat[0], pat[1], pat[2], pat[3], pat[4], pat[5], pat[6], pat[7], col, co};
    cell_q.insert(cell_q.size(), res);
    row_idx = '0;
    colour_mask = '0;
    hires_colour = '0;
    multi_col = MultiFlag;
    multi_clean = 1'b1;
  endtask

  task automatic check_cell(input cell_res_t got);
    cell_res_t want;
    logic [$bits(cell_res_t)-1:0] g, w;
    int top;
    if (cell_q.size() == 0) begin
      flag("unexpected cell result", 0, 1);
      return;
    end
    want = cell_q.pop_front();
    g = got;
    w = want;
    top = $bits(cell_res_t) - 1;
    for (int k = 0; k < NumRows; k++)
      if (g[top-8*k -: 8] != w[top-8*k -: 8])
        flag($sformatf("byte_%0d", k), w[top-8*k -: 8], g[top-8*k -: 8]);
    if (got.cell_colour != want.cell_colour)
      flag("cell_colour", want.cell_colour, got.cell_colour);
    if (got.coalesce_ok != want.coalesce_ok)
      flag("coalesce_ok", want.coalesce_ok, got.coalesce_ok);
  endtask

  // monitor: results first, their rows are always older than a row taken now
  always @(posedge clk_i) begin
    row_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_cell(out_data_o);
      if (in_valid_i && in_ready_o) begin
        encode_row(in_data_i);
        row_taken = 1'b1;
      end
    end
  end

  // row driver
  always @(negedge clk_i) begin
    if (!in_valid_i || row_taken) begin
      if (row_q.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
        in_data_i <= row_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || $urandom_range(99) >= 31;
    end
  end

  task automatic load_regs(input logic [4:0] bg, input logic [4:0] m1, input logic [4:0] m2,
                           input logic [4:0] mf);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgBackground;
    cfg_wdata_i <= bg;
    @(negedge clk_i);
    cfg_idx_i <= CfgMulticolOne;
    cfg_wdata_i <= m1;
    @(negedge clk_i);
    cfg_idx_i <= CfgMulticolTwo;
    cfg_wdata_i <= m2;
    @(negedge clk_i);
    cfg_idx_i <= CfgModeForce;
    cfg_wdata_i <= mf;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    bg_reg = bg[3:0];
    mc_one_reg = m1;
    mc_two_reg = m2;
    force_reg = mf[1:0];
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (row_q.size() != 0 || in_valid_i || cell_q.size() != 0) @(posedge clk_i);
    // rows of a partial cell may still be in the pipe
    repeat (8) @(posedge clk_i);
  endtask

  task automatic add_cell(input int kind);
    logic [31:0] flat;
    logic [3:0] ca, cb, pick;
    ca = 4'($urandom_range(15));
    cb = 4'($urandom_range(15));
    for (int y = 0; y < NumRows; y++) begin
      for (int x = 0; x < NumPix; x++) begin
        case (kind)
          0: pick = bg_reg;
          1: pick = ca;
          2: pick = $urandom_range(1) ? bg_reg : {1'b0, ca[2:0]};
          3: pick = $urandom_range(1) ? bg_reg : {1'b1, ca[2:0]};
          4: pick = $urandom_range(1) ? ca : cb;
          5, 6, 7: begin
            case ($urandom_range(9))
              0, 1, 2: pick = bg_reg;
              3, 4, 5: pick = mc_one_reg[3:0];
              6, 7, 8: pick = mc_two_reg[3:0];
              default: pick = 4'($urandom_range(15));
            endcase
          end
          default: pick = 4'($urandom_range(15));
        endcase
        flat[31-4*x -: 4] = pick;
      end
      row_q.insert(row_q.size(), flat);
    end
  endtask

  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [4:0] m1, m2;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_regs(5'd0, 5'd12, 5'd13, 5'd0);

    // background only, then a checkerboard of the extreme indices,
    // then a hires diagonal
    repeat (8) row_q.insert(row_q.size(), '0);
    for (int y = 0; y < NumRows; y++)
      row_q.insert(row_q.size(), y[0] ? 32'hF0F0F0F0 : 32'h0F0F0F0F);
    for (int y = 0; y < NumRows; y++) row_q.insert(row_q.size(), 32'h7 << (4 * y));
    wait_drained();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph)
        0: load_regs(5'd0, 5'd0, 5'd0, 5'd0);
        1: load_regs(5'd31, 5'd31, 5'd31, 5'd31);
        2: load_regs(5'd15, 5'd16, 5'd16, 5'd1);
        3: load_regs(5'd5, 5'd16, 5'd3, 5'd2);
        4: load_regs(5'd0, 5'd12, 5'd13, 5'd3);
        default: begin
          m1 = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
          m2 = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
          load_regs(5'($urandom_range(31)), m1, m2, 5'($urandom_range(31)));
        end
      endcase
      calm = (ph == 5);
      repeat (8) add_cell($urandom_range(9));
      // leave a cell open so the next settings land mid-cell
      if (ph % 3 == 2)
        repeat ($urandom_range(1, 7)) row_q.insert(row_q.size(), $urandom);
      if (ph == 7) hold_req = 1'b1;
      wait_drained();
    end
    calm = 1'b0;

    if (mismatches == 0 && cell_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
